// ===== src/c2sb_pkg.sv =====
// shared types and constants for the strided 2d convolution block
`timescale 1ns / 1ps

package c2sb_pkg;

    localparam int ACC_W   = 52;
    localparam int CFG_DW  = 7;
    localparam int CFG_IW  = 3;
    localparam int IPTR_W  = 22;
    localparam int WPTR_W  = 24;

    localparam logic [1:0] OP_PIXEL   = 2'd0;
    localparam logic [1:0] OP_WEIGHT  = 2'd1;
    localparam logic [1:0] OP_BIAS    = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_STRIDE_ROWS   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_STRIDE_COLS   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_IN_CHANNELS   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_OUT_CHANNELS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_IN_HEIGHT     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_IN_WIDTH      = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_KERNEL_HEIGHT = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_KERNEL_WIDTH  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP1,
        S_SETUP2,
        S_SETUP3,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic vld;
    } mac_ctl_t;

endpackage

// ===== src/c2sb_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
`timescale 1ns / 1ps

module c2sb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/c2sb_mac.sv =====
// multiply-accumulate pipeline with bias preload and 32-bit saturation
`timescale 1ns / 1ps

module c2sb_mac
    import c2sb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic signed [31:0] bias,
    input  logic signed [15:0] pix,
    input  logic signed [15:0] wgt,
    output logic signed [31:0] sum_sat
);

    logic signed [31:0]      prod_reg;
    logic                    prod_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            prod_reg <= pix * wgt;
        end
        acc_reg <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = ACC_W'(bias);
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // overflow when the bits above the 32-bit range are not a sign extension
    assign ovf = !((&acc_reg[ACC_W-1:31]) || !(|acc_reg[ACC_W-1:31]));

    always_comb
    begin
        if (!ovf)
        begin
            sum_sat = acc_reg[31:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sum_sat = 32'sh8000_0000;
        end
        else
        begin
            sum_sat = 32'sh7fff_ffff;
        end
    end

endmodule

// ===== src/conv2d_strided_bias.sv =====
// top level of the strided multi-channel 2d convolution block with bias
`timescale 1ns / 1ps

// Usage
// Items enter on start when busy is low. Opcodes 0, 1 and 2 write one entry of
// the pixel, weight or bias store in the accepting cycle; they give no result
// and keep busy low. Out-of-range load addresses are dropped. Opcode 3
// computes one output element: busy rises for the whole computation and the
// result shows on conv_value/status with done high for one cycle. A compute
// walks in_channels * kernel_height * kernel_width window elements; a bad
// coordinate, zero setting or store overrun skips the walk and returns status 1.
// The rate is one multiply-accumulate per cycle, set by the single read port
// of the pixel and weight memories feeding one multiplier.
// Configuration beats (cfg_valid/cfg_ready) are taken while busy is low.
// Reset returns registers to their defaults and the control to idle; store
// contents are undefined until loaded. The receiver cannot stall: each result
// beat is valid for exactly one cycle, and a new item may be accepted in it.
module conv2d_strided_bias
    import c2sb_pkg::*;
#(
    parameter int INPUT_DEPTH  = 4096,
    parameter int WEIGHT_DEPTH = 4096,
    parameter int BIAS_DEPTH   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [11:0]        load_address,
    input  logic signed [31:0] load_value,
    input  logic [5:0]         out_channel,
    input  logic [5:0]         out_row,
    input  logic [5:0]         out_col,
    output logic               done,
    output logic signed [31:0] conv_value,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data
);

    localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int BAW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam logic [31:0] IN_DEPTH_W   = 32'(INPUT_DEPTH);
    localparam logic [31:0] WT_DEPTH_W   = 32'(WEIGHT_DEPTH);
    localparam logic [31:0] BIAS_DEPTH_W = 32'(BIAS_DEPTH);

    state_t state_reg, state_next;

    logic [3:0] stride_rows_reg, stride_cols_reg;
    logic [6:0] in_channels_reg, out_channels_reg, in_height_reg, in_width_reg;
    logic [4:0] kernel_height_reg, kernel_width_reg;

    logic [5:0]  oc_reg, orow_reg, ocol_reg;
    logic [9:0]  r0_reg, c0_reg, karea_reg;
    logic [13:0] plane_reg;
    logic        zero_reg, rfit_reg, cfit_reg, err_reg;
    logic [16:0] row0_reg, ckarea_reg;
    logic [17:0] lastrow_reg;
    logic [20:0] icm1_plane_reg;
    logic [22:0] wbase_reg;
    logic [23:0] wend_reg;
    logic [IPTR_W-1:0] last_in_reg, in_base_reg;
    logic [IPTR_W-1:0] ia_reg, row_base_reg, chan_base_reg;
    logic [WPTR_W-1:0] wa_reg;
    logic [6:0]  cnt_c_reg;
    logic [4:0]  cnt_r_reg, cnt_x_reg;
    logic        drain_reg, rd_vld_reg, done_reg, status_reg;
    logic signed [31:0] conv_value_reg;

    logic       accept, accept_compute, cfg_we;
    logic       issue, bias_re, finish, err_c, last_elem;
    logic       x_wrap, r_wrap;
    mac_ctl_t   mac_ctl;
    logic signed [15:0] load_sat;
    logic       pix_we, wgt_we, bias_we;
    logic [15:0] pix_rd, wgt_rd;
    logic [31:0] bias_rd;
    logic signed [31:0] sum_sat;

    assign accept         = start && !busy;
    assign accept_compute = accept && (opcode == OP_COMPUTE);
    assign cfg_ready      = !busy;
    assign cfg_we         = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_rows_reg   <= 4'd1;
            stride_cols_reg   <= 4'd1;
            in_channels_reg   <= 7'd1;
            out_channels_reg  <= 7'd1;
            in_height_reg     <= 7'd28;
            in_width_reg      <= 7'd28;
            kernel_height_reg <= 5'd5;
            kernel_width_reg  <= 5'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRIDE_ROWS:   stride_rows_reg   <= cfg_data[3:0];
                CFG_STRIDE_COLS:   stride_cols_reg   <= cfg_data[3:0];
                CFG_IN_CHANNELS:   in_channels_reg   <= cfg_data[6:0];
                CFG_OUT_CHANNELS:  out_channels_reg  <= cfg_data[6:0];
                CFG_IN_HEIGHT:     in_height_reg     <= cfg_data[6:0];
                CFG_IN_WIDTH:      in_width_reg      <= cfg_data[6:0];
                CFG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[4:0];
                CFG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // loads
    always_comb
    begin
        if (load_value > 32'sd32767)
        begin
            load_sat = 16'sh7fff;
        end
        else if (load_value < -32'sd32768)
        begin
            load_sat = 16'sh8000;
        end
        else
        begin
            load_sat = load_value[15:0];
        end
    end

    assign pix_we  = accept && (opcode == OP_PIXEL) && (32'(load_address) < IN_DEPTH_W);
    assign wgt_we  = accept && (opcode == OP_WEIGHT) && (32'(load_address) < WT_DEPTH_W);
    assign bias_we = accept && (opcode == OP_BIAS) && (32'(load_address) < BIAS_DEPTH_W);

    c2sb_ram #(
        .WIDTH (16),
        .DEPTH (INPUT_DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (IAW'(load_address)),
        .wdata (load_sat),
        .re    (issue),
        .raddr (ia_reg[IAW-1:0]),
        .rdata (pix_rd)
    );

    c2sb_ram #(
        .WIDTH (16),
        .DEPTH (WEIGHT_DEPTH)
    ) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (WAW'(load_address)),
        .wdata (load_sat),
        .re    (issue),
        .raddr (wa_reg[WAW-1:0]),
        .rdata (wgt_rd)
    );

    c2sb_ram #(
        .WIDTH (32),
        .DEPTH (BIAS_DEPTH)
    ) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (BAW'(load_address)),
        .wdata (load_value),
        .re    (bias_re),
        .raddr (BAW'(oc_reg)),
        .rdata (bias_rd)
    );

    c2sb_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .bias    (bias_rd),
        .pix     (pix_rd),
        .wgt     (wgt_rd),
        .sum_sat (sum_sat)
    );

    assign err_c = zero_reg || !rfit_reg || !cfit_reg
                   || ({1'b0, oc_reg} >= out_channels_reg)
                   || (32'(oc_reg) >= BIAS_DEPTH_W)
                   || (32'(last_in_reg) >= IN_DEPTH_W)
                   || (32'(wend_reg) > WT_DEPTH_W);

    assign x_wrap    = (cnt_x_reg == kernel_width_reg - 5'd1);
    assign r_wrap    = (cnt_r_reg == kernel_height_reg - 5'd1);
    assign last_elem = x_wrap && r_wrap && (cnt_c_reg == in_channels_reg - 7'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept_compute) state_next = S_SETUP1;
            S_SETUP1: state_next = S_SETUP2;
            S_SETUP2: state_next = S_SETUP3;
            S_SETUP3: state_next = S_CHECK;
            S_CHECK:  state_next = err_c ? S_FINISH : S_MAC;
            S_MAC:    if (last_elem) state_next = S_DRAIN;
            S_DRAIN:  if (drain_reg) state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        issue         = (state_reg == S_MAC);
        bias_re       = (state_reg == S_SETUP1);
        finish        = (state_reg == S_FINISH);
        mac_ctl.clear = (state_reg == S_CHECK);
        mac_ctl.vld   = rd_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            drain_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drain_reg  <= (state_reg == S_DRAIN) && !drain_reg;
            rd_vld_reg <= issue;
            done_reg   <= finish;
        end
    end

    // address setup and window walk
    always_ff @(posedge clk)
    begin
        if (accept_compute)
        begin
            oc_reg   <= out_channel;
            orow_reg <= out_row;
            ocol_reg <= out_col;
        end
        case (state_reg)
            S_SETUP1:
            begin
                r0_reg    <= 10'(orow_reg) * 10'(stride_rows_reg);
                c0_reg    <= 10'(ocol_reg) * 10'(stride_cols_reg);
                plane_reg <= 14'(in_height_reg) * 14'(in_width_reg);
                karea_reg <= 10'(kernel_height_reg) * 10'(kernel_width_reg);
                zero_reg  <= (stride_rows_reg == 4'd0) || (stride_cols_reg == 4'd0)
                             || (in_channels_reg == 7'd0) || (out_channels_reg == 7'd0)
                             || (in_height_reg == 7'd0) || (in_width_reg == 7'd0)
                             || (kernel_height_reg == 5'd0) || (kernel_width_reg == 5'd0);
            end
            S_SETUP2:
            begin
                row0_reg       <= 17'(r0_reg) * 17'(in_width_reg);
                lastrow_reg    <= 18'(11'(r0_reg) + 11'(kernel_height_reg) - 11'd1)
                                  * 18'(in_width_reg);
                icm1_plane_reg <= 21'(in_channels_reg - 7'd1) * 21'(plane_reg);
                ckarea_reg     <= 17'(in_channels_reg) * 17'(karea_reg);
                rfit_reg       <= (11'(r0_reg) + 11'(kernel_height_reg)) <= 11'(in_height_reg);
                cfit_reg       <= (11'(c0_reg) + 11'(kernel_width_reg)) <= 11'(in_width_reg);
            end
            S_SETUP3:
            begin
                wbase_reg   <= 23'(oc_reg) * 23'(ckarea_reg);
                wend_reg    <= 24'(7'(oc_reg) + 7'd1) * 24'(ckarea_reg);
                last_in_reg <= IPTR_W'(icm1_plane_reg) + IPTR_W'(lastrow_reg)
                               + IPTR_W'(c0_reg) + IPTR_W'(kernel_width_reg) - IPTR_W'(1);
                in_base_reg <= IPTR_W'(row0_reg) + IPTR_W'(c0_reg);
            end
            S_CHECK:
            begin
                err_reg       <= err_c;
                ia_reg        <= in_base_reg;
                row_base_reg  <= in_base_reg;
                chan_base_reg <= in_base_reg;
                wa_reg        <= WPTR_W'(wbase_reg);
                cnt_c_reg     <= 7'd0;
                cnt_r_reg     <= 5'd0;
                cnt_x_reg     <= 5'd0;
            end
            S_MAC:
            begin
                wa_reg <= wa_reg + WPTR_W'(1);
                if (!x_wrap)
                begin
                    cnt_x_reg <= cnt_x_reg + 5'd1;
                    ia_reg    <= ia_reg + IPTR_W'(1);
                end
                else if (!r_wrap)
                begin
                    cnt_x_reg    <= 5'd0;
                    cnt_r_reg    <= cnt_r_reg + 5'd1;
                    row_base_reg <= row_base_reg + IPTR_W'(in_width_reg);
                    ia_reg       <= row_base_reg + IPTR_W'(in_width_reg);
                end
                else
                begin
                    cnt_x_reg     <= 5'd0;
                    cnt_r_reg     <= 5'd0;
                    cnt_c_reg     <= cnt_c_reg + 7'd1;
                    chan_base_reg <= chan_base_reg + IPTR_W'(plane_reg);
                    row_base_reg  <= chan_base_reg + IPTR_W'(plane_reg);
                    ia_reg        <= chan_base_reg + IPTR_W'(plane_reg);
                end
            end
            default:
            begin
            end
        endcase
        if (finish)
        begin
            conv_value_reg <= err_reg ? 32'sd0 : sum_sat;
            status_reg     <= err_reg;
        end
    end

    assign done       = done_reg;
    assign conv_value = conv_value_reg;
    assign status     = status_reg;

endmodule

// ===== src/c2sb_chk.sv =====
// port-level checker for the convolution block and its bind
`timescale 1ns / 1ps

module c2sb_chk
    import c2sb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         opcode,
    input logic               done,
    input logic signed [31:0] conv_value,
    input logic               status
);

    // a result beat always lands with the block back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (conv_value == 32'sd0))
        else $error("error result with nonzero value");

    // one compute gives one beat
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_COMPUTE)) |=> busy)
        else $error("compute accepted without going busy");

    // loads finish in their own cycle and give no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != OP_COMPUTE)) |=> (!busy && !done))
        else $error("load caused busy or a result");

endmodule

bind conv2d_strided_bias c2sb_chk u_chk (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for conv2d_strided_bias: directed and random loads and computes
`timescale 1ns / 1ps

module testbench;
    import c2sb_pkg::*;

    localparam int INPUT_DEPTH  = 4096;
    localparam int WEIGHT_DEPTH = 4096;
    localparam int BIAS_DEPTH   = 64;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } conv_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [11:0]        load_address;
    logic signed [31:0] load_value;
    logic [5:0]         out_channel;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic               done;
    logic signed [31:0] conv_value;
    logic               status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index;
    logic [CFG_DW-1:0]  cfg_data;

    conv_result_t       conv_expected[$];
    conv_result_t       beat_want;
    logic signed [15:0] pixel_mem  [INPUT_DEPTH];
    logic signed [15:0] weight_mem [WEIGHT_DEPTH];
    logic signed [31:0] bias_mem   [BIAS_DEPTH];
    bit                 pixel_set  [INPUT_DEPTH];
    bit                 weight_set [WEIGHT_DEPTH];
    bit                 bias_set   [BIAS_DEPTH];

    logic [3:0]         stride_rows_q;
    logic [3:0]         stride_cols_q;
    logic [6:0]         in_ch_q;
    logic [6:0]         out_ch_q;
    logic [6:0]         in_h_q;
    logic [6:0]         in_w_q;
    logic [4:0]         kern_h_q;
    logic [4:0]         kern_w_q;

    int                 error_count = 0;
    int                 items_sent  = 0;
    int                 gap_pct     = 0;

    conv2d_strided_bias #(
        .INPUT_DEPTH  (INPUT_DEPTH),
        .WEIGHT_DEPTH (WEIGHT_DEPTH),
        .BIAS_DEPTH   (BIAS_DEPTH)
    ) dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [15:0] sat_q88(input logic signed [31:0] v);
        if (v > 32'sd32767)
            return 16'sh7fff;
        if (v < -32'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int cap6(input int v);
        return (v > 63) ? 63 : v;
    endfunction

    function automatic void output_extent(output int oh, output int ow);
        oh = 0;
        ow = 0;
        if (stride_rows_q == 0 || stride_cols_q == 0 || in_ch_q == 0 || out_ch_q == 0 ||
            in_h_q == 0 || in_w_q == 0 || kern_h_q == 0 || kern_w_q == 0)
            return;
        if (kern_h_q > in_h_q || kern_w_q > in_w_q)
            return;
        oh = (int'(in_h_q) - int'(kern_h_q)) / int'(stride_rows_q) + 1;
        ow = (int'(in_w_q) - int'(kern_w_q)) / int'(stride_cols_q) + 1;
    endfunction

    // true when the compute is in range and reads the stores
    function automatic bit window_reads(input logic [5:0] oc, row, col,
                                        output longint r0, c0, wbase);
        int     oh;
        int     ow;
        longint plane;
        longint karea;
        longint last_in;
        longint last_w;
        r0 = 0;
        c0 = 0;
        wbase = 0;
        output_extent(oh, ow);
        if (oh == 0 || int'(oc) >= int'(out_ch_q) || int'(row) >= oh || int'(col) >= ow ||
            int'(oc) >= BIAS_DEPTH)
            return 1'b0;
        plane = longint'(in_h_q) * longint'(in_w_q);
        karea = longint'(kern_h_q) * longint'(kern_w_q);
        r0 = longint'(row) * longint'(stride_rows_q);
        c0 = longint'(col) * longint'(stride_cols_q);
        wbase = longint'(oc) * longint'(in_ch_q) * karea;
        last_in = (longint'(in_ch_q) - 1) * plane
                  + (r0 + longint'(kern_h_q) - 1) * longint'(in_w_q)
                  + c0 + longint'(kern_w_q) - 1;
        last_w = wbase + longint'(in_ch_q) * karea - 1;
        return last_in < INPUT_DEPTH && last_w < WEIGHT_DEPTH;
    endfunction

    function automatic longint pixel_index(input longint r0, c0, input int c, r, x);
        return longint'(c) * longint'(in_h_q) * longint'(in_w_q)
               + (r0 + r) * longint'(in_w_q) + c0 + x;
    endfunction

    function automatic longint weight_index(input longint wbase, input int c, r, x);
        return wbase + longint'(c) * longint'(kern_h_q) * longint'(kern_w_q)
               + longint'(r) * longint'(kern_w_q) + x;
    endfunction

    function automatic conv_result_t predict_output(input logic [5:0] oc, row, col);
        conv_result_t res;
        longint       r0;
        longint       c0;
        longint       wbase;
        longint       acc;
        int           c;
        int           r;
        int           x;
        res.value = '0;
        res.status = 1'b1;
        if (!window_reads(oc, row, col, r0, c0, wbase))
            return res;
        acc = longint'(bias_mem[oc]);
        for (c = 0; c < int'(in_ch_q); c++)
            for (r = 0; r < int'(kern_h_q); r++)
                for (x = 0; x < int'(kern_w_q); x++)
                    acc += longint'(pixel_mem[pixel_index(r0, c0, c, r, x)])
                           * longint'(weight_mem[weight_index(wbase, c, r, x)]);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        res.value = acc[31:0];
        res.status = 1'b0;
        return res;
    endfunction

    function automatic logic [31:0] pick_load_value();
        logic [15:0] half;
        half = 16'($urandom());
        case ($urandom_range(0, 5))
            0: return $urandom();
            1, 2: return {{16{half[15]}}, half};
            3:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h00007fff;
                    3: return 32'hffff8000;
                    4: return 32'h00008000;
                    default: return 32'hffff7fff;
                endcase
            end
            default: return 32'($urandom_range(0, 1023)) - 32'd512;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (conv_expected.size() == 0)
            begin
                $error("conv_value: expected none, actual %0d (status %0d)",
                       conv_value, status);
                error_count++;
            end
            else
            begin
                beat_want = conv_expected.pop_front();
                if (conv_value !== beat_want.value)
                begin
                    $error("conv_value: expected %0d, actual %0d", beat_want.value, conv_value);
                    error_count++;
                end
                if (status !== beat_want.status)
                begin
                    $error("status: expected %0d, actual %0d", beat_want.status, status);
                    error_count++;
                end
            end
        end
    end

    task automatic idle_gap(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                             input logic [31:0] value, input logic [5:0] oc, row, col);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            idle_gap($urandom_range(1, 9));
        @(negedge clk);
        start        <= 1'b1;
        opcode       <= op;
        load_address <= addr;
        load_value   <= value;
        out_channel  <= oc;
        out_row      <= row;
        out_col      <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (op)
            OP_PIXEL:
            begin
                pixel_mem[addr] = sat_q88(value);
                pixel_set[addr] = 1'b1;
            end
            OP_WEIGHT:
            begin
                weight_mem[addr] = sat_q88(value);
                weight_set[addr] = 1'b1;
            end
            OP_BIAS:
            begin
                if (addr < BIAS_DEPTH)
                begin
                    bias_mem[addr[5:0]] = value;
                    bias_set[addr[5:0]] = 1'b1;
                end
            end
            default: conv_expected.push_back(predict_output(oc, row, col));
        endcase
        items_sent++;
    endtask

    task automatic load_item(input logic [1:0] op, input logic [11:0] addr,
                             input logic [31:0] value);
        send_item(op, addr, value, 6'($urandom()), 6'($urandom()), 6'($urandom()));
    endtask

    task automatic compute_item(input logic [5:0] oc, row, col);
        send_item(OP_COMPUTE, 12'($urandom()), $urandom(), oc, row, col);
    endtask

    // loads any entry of the window not yet written, optionally rewrites a few, then computes
    task automatic request_output(input logic [5:0] oc, row, col, input int touches);
        longint     r0;
        longint     c0;
        longint     wbase;
        longint     ia;
        longint     wa;
        int         c;
        int         r;
        int         x;
        int         k;
        if (window_reads(oc, row, col, r0, c0, wbase))
        begin
            for (c = 0; c < int'(in_ch_q); c++)
                for (r = 0; r < int'(kern_h_q); r++)
                    for (x = 0; x < int'(kern_w_q); x++)
                    begin
                        ia = pixel_index(r0, c0, c, r, x);
                        wa = weight_index(wbase, c, r, x);
                        if (!pixel_set[ia])
                            load_item(OP_PIXEL, ia[11:0], pick_load_value());
                        if (!weight_set[wa])
                            load_item(OP_WEIGHT, wa[11:0], pick_load_value());
                    end
            if (!bias_set[oc])
                load_item(OP_BIAS, {6'd0, oc}, pick_load_value());
            for (k = 0; k < touches; k++)
            begin
                c = $urandom_range(int'(in_ch_q) - 1, 0);
                r = $urandom_range(int'(kern_h_q) - 1, 0);
                x = $urandom_range(int'(kern_w_q) - 1, 0);
                ia = pixel_index(r0, c0, c, r, x);
                wa = weight_index(wbase, c, r, x);
                case ($urandom_range(0, 2))
                    0: load_item(OP_PIXEL, ia[11:0], pick_load_value());
                    1: load_item(OP_WEIGHT, wa[11:0], pick_load_value());
                    default: load_item(OP_BIAS, {6'd0, oc}, pick_load_value());
                endcase
            end
        end
        compute_item(oc, row, col);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (conv_expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_STRIDE_ROWS:   stride_rows_q = data[3:0];
            CFG_STRIDE_COLS:   stride_cols_q = data[3:0];
            CFG_IN_CHANNELS:   in_ch_q       = data[6:0];
            CFG_OUT_CHANNELS:  out_ch_q      = data[6:0];
            CFG_IN_HEIGHT:     in_h_q        = data[6:0];
            CFG_IN_WIDTH:      in_w_q        = data[6:0];
            CFG_KERNEL_HEIGHT: kern_h_q      = data[4:0];
            CFG_KERNEL_WIDTH:  kern_w_q      = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [6:0] sr, sc, ic, occ, ih, iw, kh, kw);
        settle();
        write_reg(CFG_STRIDE_ROWS, sr);
        write_reg(CFG_STRIDE_COLS, sc);
        write_reg(CFG_IN_CHANNELS, ic);
        write_reg(CFG_OUT_CHANNELS, occ);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_KERNEL_HEIGHT, kh);
        write_reg(CFG_KERNEL_WIDTH, kw);
    endtask

    task automatic pick_random_settings();
        logic [6:0] kh;
        logic [6:0] kw;
        kh = 7'($urandom_range(1, 4));
        kw = 7'($urandom_range(1, 4));
        apply_settings(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                       7'($urandom_range(1, 3)), 7'($urandom_range(1, 8)),
                       kh + 7'($urandom_range(0, 12)), kw + 7'($urandom_range(0, 12)),
                       kh, kw);
    endtask

    task automatic run_random_phase(input int budget);
        int first;
        int oh;
        int ow;
        int pick;
        first = items_sent;
        output_extent(oh, ow);
        while (items_sent - first < budget)
        begin
            if (gap_pct != 0 && $urandom_range(0, 49) == 0)
                settle();
            pick = $urandom_range(0, 99);
            if (pick < 55 && oh > 0)
                request_output(6'($urandom_range(cap6(int'(out_ch_q) - 1), 0)),
                               6'($urandom_range(cap6(oh - 1), 0)),
                               6'($urandom_range(cap6(ow - 1), 0)), $urandom_range(0, 3));
            else if (pick < 70)
                load_item(2'($urandom_range(0, 2)), 12'($urandom()), pick_load_value());
            else if (pick < 85)
                request_output(6'($urandom()), 6'($urandom()), 6'($urandom()), 0);
            else
            begin
                // just past the edge of the output
                case ($urandom_range(0, 2))
                    0: request_output(6'(cap6(int'(out_ch_q))), 0, 0, 0);
                    1: request_output(0, 6'(cap6(oh)), 6'($urandom_range(cap6(ow), 0)), 0);
                    default: request_output(0, 6'($urandom_range(cap6(oh), 0)),
                                            6'(cap6(ow)), 0);
                endcase
            end
        end
    endtask

    task automatic test_saturation_and_bounds();
        apply_settings(1, 1, 1, 1, 2, 2, 2, 2);
        load_item(OP_PIXEL, 0, 32'h7fffffff);
        load_item(OP_PIXEL, 1, 32'h00007fff);
        load_item(OP_PIXEL, 2, 32'h12345678);
        load_item(OP_PIXEL, 3, 32'h00008000);
        load_item(OP_WEIGHT, 0, 32'h7fffffff);
        load_item(OP_WEIGHT, 1, 32'h00007fff);
        load_item(OP_WEIGHT, 2, 32'h40000000);
        load_item(OP_WEIGHT, 3, 32'h00007fff);
        load_item(OP_BIAS, 0, 32'h7fffffff);
        compute_item(0, 0, 0);
        load_item(OP_WEIGHT, 0, 32'h80000000);
        load_item(OP_WEIGHT, 1, 32'hffff8000);
        load_item(OP_WEIGHT, 2, 32'hfff08000);
        load_item(OP_WEIGHT, 3, 32'hffff7fff);
        load_item(OP_BIAS, 0, 32'h80000000);
        compute_item(0, 0, 0);
        // bias address past the store is dropped
        load_item(OP_BIAS, 12'hfff, 32'h7fffffff);
        compute_item(0, 0, 0);
        compute_item(0, 1, 0);
        compute_item(0, 0, 1);
        compute_item(1, 0, 0);
        compute_item(63, 63, 63);
    endtask

    task automatic test_degenerate_settings();
        logic [6:0] s [8];
        int         i;
        for (i = 0; i < 8; i++)
        begin
            s = '{7'd1, 7'd1, 7'd1, 7'd1, 7'd8, 7'd8, 7'd2, 7'd2};
            s[i] = 7'd0;
            apply_settings(s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]);
            request_output(0, 0, 0, 0);
        end
        apply_settings(1, 1, 1, 1, 8, 8, 9, 2);
        request_output(0, 0, 0, 0);
        apply_settings(1, 1, 1, 1, 8, 8, 2, 9);
        request_output(0, 0, 0, 0);
        // window past the pixel store
        apply_settings(1, 1, 2, 1, 64, 64, 1, 1);
        request_output(0, 0, 0, 0);
        // filter past the weight store, then the last one that fits
        apply_settings(1, 1, 17, 64, 2, 2, 2, 2);
        request_output(60, 0, 0, 0);
        request_output(59, 0, 0, 0);
        apply_settings(7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f);
        request_output(0, 0, 0, 0);
    endtask

    task automatic test_size_extremes();
        apply_settings(1, 1, 1, 64, 64, 64, 1, 1);
        request_output(63, 63, 63, 1);
        request_output(0, 0, 0, 0);
        request_output(32, 17, 40, 0);
        apply_settings(8, 8, 1, 1, 16, 9, 16, 1);
        request_output(0, 0, 1, 0);
        request_output(0, 1, 0, 0);
        request_output(0, 0, 2, 0);
        apply_settings(7'h7f, 8, 1, 1, 3, 16, 1, 16);
        request_output(0, 0, 0, 0);
        request_output(0, 1, 0, 0);
        apply_settings(1, 1, 64, 2, 1, 1, 1, 1);
        request_output(1, 0, 0, 0);
        request_output(0, 0, 0, 0);
        apply_settings(1, 1, 1, 1, 1, 1, 1, 1);
        request_output(0, 0, 0, 2);
        request_output(0, 0, 1, 0);
    endtask

    task automatic test_random_settings();
        int phase;
        for (phase = 0; phase < 7; phase++)
        begin
            pick_random_settings();
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            run_random_phase(40);
        end
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        pick_random_settings();
        run_random_phase(60);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_PIXEL;
        load_address  = '0;
        load_value    = '0;
        out_channel   = '0;
        out_row       = '0;
        out_col       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_STRIDE_ROWS;
        cfg_data      = '0;
        stride_rows_q = 4'd1;
        stride_cols_q = 4'd1;
        in_ch_q       = 7'd1;
        out_ch_q      = 7'd1;
        in_h_q        = 7'd28;
        in_w_q        = 7'd28;
        kern_h_q      = 5'd5;
        kern_w_q      = 5'd5;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_pct = 25;
        test_saturation_and_bounds();
        test_degenerate_settings();
        test_size_extremes();
        test_random_settings();
        test_back_to_back();
        settle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
